// ===== rtl/dvrt_pkg.sv =====
`default_nettype none

package dvrt_pkg;

   localparam logic [15:0] COST_NONE  = 16'hFFFE;
   localparam logic [15:0] COST_START = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_UPDATE     = 2'd0,
      CMD_QUERY      = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_REMOVE_ALL = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  dest_index;
      logic [15:0] hop_id;
      logic [15:0] route_cost;
   } req_type;

   typedef struct packed {
      logic [15:0] best_hop;
      logic [15:0] best_cost;
      logic        route_found;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] hop;
      logic [15:0] cost;
      logic        valid;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic [15:0] best_hop;
      logic [15:0] best_cost;
      logic        route_found;
   } route_type;

   typedef struct packed {
      logic       hit;
      status_type status;
   } edit_info_type;

endpackage

`default_nettype wire

// ===== rtl/dvrt_row_mem.sv =====
`default_nettype none

module dvrt_row_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 264,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/dvrt_row_edit.sv =====
`default_nettype none

module dvrt_row_edit import dvrt_pkg::*; #(
   parameter int NUM_SLOTS = 8
) (
   input  wire slot_type [NUM_SLOTS-1:0] row_data,
   input  wire logic     [1:0]           command,
   input  wire logic     [15:0]          hop_id,
   input  wire logic     [15:0]          route_cost,
   output slot_type      [NUM_SLOTS-1:0] new_row,
   output edit_info_type                 info
);

   logic [NUM_SLOTS-1:0] match_vec;
   logic [NUM_SLOTS-1:0] free_vec;
   logic [NUM_SLOTS-1:0] match_first;
   logic [NUM_SLOTS-1:0] free_first;
   logic [NUM_SLOTS-1:0] sel_vec;

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         match_vec[s] = row_data[s].valid && (row_data[s].hop == hop_id);
         free_vec[s]  = !row_data[s].valid;
      end
   end

   // isolate lowest set bit: lowest matching slot, lowest free slot
   assign match_first = match_vec & (~match_vec + NUM_SLOTS'(1));
   assign free_first  = free_vec & (~free_vec + NUM_SLOTS'(1));
   assign sel_vec     = (|match_vec) ? match_first : free_first;

   always_comb begin
      new_row     = row_data;
      info.hit    = |match_vec;
      info.status = STATUS_DONE;
      case (command)
         CMD_UPDATE: begin
            if (!(|sel_vec)) begin
               info.status = STATUS_FULL;
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (sel_vec[s]) begin
                  new_row[s].hop   = hop_id;
                  new_row[s].cost  = route_cost;
                  new_row[s].valid = 1'b1;
               end
            end
         end
         CMD_REMOVE, CMD_REMOVE_ALL: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (match_vec[s]) begin
                  new_row[s].valid = 1'b0;
               end
            end
            info.status = (|match_vec) ? STATUS_DONE : STATUS_NOT_FOUND;
         end
         default: begin
            new_row = row_data;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dvrt_best.sv =====
`default_nettype none

module dvrt_best import dvrt_pkg::*; #(
   parameter int NUM_SLOTS = 8
) (
   input  wire slot_type [NUM_SLOTS-1:0] row_data,
   output route_type                     route
);

   localparam int LEVELS = $clog2(NUM_SLOTS);
   localparam int LEAVES = 1 << LEVELS;

   slot_type node [1:2*LEAVES-1];

   // left side wins ties, so the lowest slot wins among equal costs
   function automatic slot_type slot_pick(input slot_type a, input slot_type b);
      slot_type r;
      r = a;
      if (!a.valid || (b.valid && (b.cost < a.cost))) begin
         r = b;
      end
      r.valid = a.valid | b.valid;
      return r;
   endfunction

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < NUM_SLOTS) begin : g_used
         assign node[LEAVES+j] = row_data[j];
      end else begin : g_pad
         assign node[LEAVES+j] = '0;
      end
   end

   for (genvar i = 1; i < LEAVES; i++) begin : g_node
      assign node[i] = slot_pick(node[2*i], node[2*i+1]);
   end

   // all valid costs at the start value: nothing strictly below it, hop stays 0
   assign route.route_found = node[1].valid;
   assign route.best_cost   = node[1].valid ? node[1].cost : COST_NONE;
   assign route.best_hop    = (node[1].valid && (node[1].cost != COST_START)) ?
                              node[1].hop : 16'd0;

endmodule

`default_nettype wire

// ===== rtl/distance_vector_route_table_core.sv =====
`default_nettype none

// Channel   Ports                            Payload
// request   req_valid, req_stall, req_data   command, dest_index, hop_id, route_cost
// response  rsp_valid, rsp_stall, rsp_data   best_hop, best_cost, route_found, status
//
// Update, query and remove each read the row from the table memory, then edit it and
// write it back; the best-route select fills the output register while the next
// transaction is read.
// Remove-everywhere sweeps every memory row, one memory row per cycle.
// After reset a clearing pass over every table row keeps req_stall high.
// A stalled response holds one finished result plus one more in flight.

module distance_vector_route_table_core import dvrt_pkg::*; #(
   parameter int NUM_DEST  = 64,
   parameter int NUM_SLOTS = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int RW    = $clog2(NUM_DEST);
   localparam int ROW_W = SLOT_W * NUM_SLOTS;

   state_type state_ff, state_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [1:0]    cmd_ff;
   logic [RW-1:0] dest_ff;
   logic [15:0]   hop_ff;
   logic [15:0]   cost_ff;
   logic          oor_ff;
   logic          hit_ff;
   logic [1:0]    stat_ff;
   slot_type [NUM_SLOTS-1:0] mod_row_ff;
   rsp_type       rsp_ff;

   logic          accept;
   logic          fire;
   logic          sweep_last;
   logic          oor_req;
   logic [RW-1:0] dest_req;

   logic          wr_en;
   logic [RW-1:0] wr_addr;
   logic [RW-1:0] rd_addr;
   logic [ROW_W-1:0] wr_data;
   logic [ROW_W-1:0] rd_data;

   slot_type [NUM_SLOTS-1:0] rd_row;
   slot_type [NUM_SLOTS-1:0] new_row;
   edit_info_type            info;
   route_type                route;

   assign oor_req    = {26'd0, req_data.dest_index} >= 32'(NUM_DEST);
   assign dest_req   = RW'(req_data.dest_index);
   assign sweep_last = cnt_ff == RW'(NUM_DEST - 1);

   assign fire      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) && (!pend_ff || fire));
   assign accept    = req_valid && !req_stall;

   assign rd_row = rd_data;

   dvrt_row_mem #(
      .DEPTH (NUM_DEST),
      .WIDTH (ROW_W),
      .AW    (RW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dvrt_row_edit #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_edit (
      .row_data   (rd_row),
      .command    (cmd_ff),
      .hop_id     (hop_ff),
      .route_cost (cost_ff),
      .new_row    (new_row),
      .info       (info)
   );

   dvrt_best #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_best (
      .row_data (mod_row_ff),
      .route    (route)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rd_addr  = dest_req;
      wr_en    = 1'b0;
      wr_addr  = dest_ff;
      wr_data  = new_row;
      pend_in  = fire ? 1'b0 : pend_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + RW'(1);
            if (sweep_last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (!oor_req && (req_data.command == CMD_REMOVE_ALL)) begin
                  rd_addr  = '0;
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            wr_en    = !oor_ff;
            pend_in  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            rd_addr = cnt_ff + RW'(1);
            cnt_in  = cnt_ff + RW'(1);
            if (sweep_last) begin
               rd_addr  = '0;
               cnt_in   = '0;
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_data.command;
         dest_ff <= dest_req;
         hop_ff  <= req_data.hop_id;
         cost_ff <= req_data.route_cost;
         oor_ff  <= oor_req;
         hit_ff  <= 1'b0;
      end
      if (state_ff == ST_MODIFY) begin
         mod_row_ff <= oor_ff ? '0 : new_row;
         stat_ff    <= oor_ff ? STATUS_NOT_FOUND : info.status;
      end
      if (state_ff == ST_SWEEP) begin
         hit_ff <= hit_ff | info.hit;
         if (cnt_ff == dest_ff) begin
            mod_row_ff <= new_row;
         end
         if (sweep_last) begin
            stat_ff <= (hit_ff | info.hit) ? STATUS_DONE : STATUS_NOT_FOUND;
         end
      end
      if (fire) begin
         rsp_ff.best_hop    <= route.best_hop;
         rsp_ff.best_cost   <= route.best_cost;
         rsp_ff.route_found <= route.route_found;
         if (cmd_ff == CMD_QUERY) begin
            rsp_ff.status <= route.route_found ? STATUS_DONE : STATUS_NOT_FOUND;
         end else begin
            rsp_ff.status <= stat_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_modify_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> !pend_ff)
      else $error("edit stage entered with a result still pending");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) || (state_ff == ST_SWEEP)) |-> req_stall)
      else $error("request accepted during a table pass");

   a_pending_kept: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && rsp_stall) |=> pend_ff)
      else $error("pending result dropped while response stalled");

endmodule

`default_nettype wire
